>>> hdl/kps_pkg.sv
`timescale 1ns / 1ps

package kps_pkg;

  localparam int ID_W         = 16;
  localparam int COORD_W      = 16;
  localparam int DIST_W       = 36;
  localparam int SQ_W         = 2 * (COORD_W + 1);
  localparam int RANK_W       = 3;
  localparam int ML_W         = 4;
  localparam int RESULT_LIMIT = 8;
  localparam logic [ML_W-1:0] ML_RESET = 4'd4;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_QUERY_X    = 2'd0,
    REG_QUERY_Y    = 2'd1,
    REG_QUERY_Z    = 2'd2,
    REG_MAX_LIGHTS = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [ID_W-1:0]           id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } light_t;

  typedef struct packed {
    logic               valid;
    logic [ID_W-1:0]    id;
    logic [DIST_W-1:0]  sq_dist;
    logic               last;
  } dist_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] sq_dist;
  } slot_t;

endpackage

>>> hdl/kps_channels.sv
`timescale 1ns / 1ps

interface kps_light_if;
  logic                                valid;
  logic                                ready;
  logic [kps_pkg::ID_W-1:0]            light_id;
  logic signed [kps_pkg::COORD_W-1:0]  light_x;
  logic signed [kps_pkg::COORD_W-1:0]  light_y;
  logic signed [kps_pkg::COORD_W-1:0]  light_z;
  logic                                last_light;

  modport source (output valid, light_id, light_x, light_y, light_z, last_light,
                  input ready);
  modport sink   (input valid, light_id, light_x, light_y, light_z, last_light,
                  output ready);
endinterface

interface kps_result_if;
  logic                            valid;
  logic                            ready;
  logic [kps_pkg::RANK_W-1:0]      rank;
  logic [kps_pkg::ID_W-1:0]        chosen_id;
  logic [kps_pkg::DIST_W-1:0]      squared_distance;
  logic                            last_result;

  modport source (output valid, rank, chosen_id, squared_distance, last_result,
                  input ready);
  modport sink   (input valid, rank, chosen_id, squared_distance, last_result,
                  output ready);
endinterface

>>> hdl/kps_dist.sv
`timescale 1ns / 1ps

module kps_dist (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               adv,
  input  logic                               in_valid,
  input  kps_pkg::light_t                    in_light,
  input  logic signed [kps_pkg::COORD_W-1:0] query_x,
  input  logic signed [kps_pkg::COORD_W-1:0] query_y,
  input  logic signed [kps_pkg::COORD_W-1:0] query_z,
  output kps_pkg::dist_item_t                item
);
  import kps_pkg::*;

  // stage 1: captured candidate
  logic   s1_valid;
  light_t s1;

  // stage 2: per-axis squares
  logic              s2_valid;
  logic [ID_W-1:0]   s2_id;
  logic              s2_last;
  logic [SQ_W-1:0]   s2_sx;
  logic [SQ_W-1:0]   s2_sy;
  logic [SQ_W-1:0]   s2_sz;

  logic signed [COORD_W:0] dx;
  logic signed [COORD_W:0] dy;
  logic signed [COORD_W:0] dz;
  logic signed [SQ_W-1:0]  sqx;
  logic signed [SQ_W-1:0]  sqy;
  logic signed [SQ_W-1:0]  sqz;

  always_comb begin
    dx  = {s1.x[COORD_W-1], s1.x} - {query_x[COORD_W-1], query_x};
    dy  = {s1.y[COORD_W-1], s1.y} - {query_y[COORD_W-1], query_y};
    dz  = {s1.z[COORD_W-1], s1.z} - {query_z[COORD_W-1], query_z};
    sqx = dx * dx;
    sqy = dy * dy;
    sqz = dz * dz;
  end

  // valid bits are reset, payload only moves with the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      item.valid <= 1'b0;
    end else if (adv) begin
      s1_valid   <= in_valid;
      s2_valid   <= s1_valid;
      item.valid <= s2_valid;
    end
    if (adv) begin
      s1           <= in_light;
      s2_id        <= s1.id;
      s2_last      <= s1.last;
      s2_sx        <= SQ_W'(sqx);
      s2_sy        <= SQ_W'(sqy);
      s2_sz        <= SQ_W'(sqz);
      item.id      <= s2_id;
      item.last    <= s2_last;
      item.sq_dist <= DIST_W'(s2_sx) + DIST_W'(s2_sy) + DIST_W'(s2_sz);
    end
  end

endmodule

>>> hdl/kps_sorter.sv
`timescale 1ns / 1ps

module kps_sorter #(
  parameter int SLOTS = 8,
  parameter int KW    = $clog2(SLOTS + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  kps_pkg::dist_item_t          item,
  input  logic [kps_pkg::ML_W-1:0]     max_lights,
  output logic                         load,
  output logic [KW-1:0]                load_count,
  output kps_pkg::slot_t               list [SLOTS]
);
  import kps_pkg::*;

  localparam int CAP = (SLOTS < RESULT_LIMIT) ? SLOTS : RESULT_LIMIT;

  slot_t         slots [SLOTS];
  logic [KW-1:0] fill;
  logic [KW-1:0] fill_next;

  logic [ML_W-1:0] k4;
  logic [KW-1:0]   k;
  logic [KW-1:0]   fill_eff;
  logic [SLOTS-1:0] le;
  logic [KW-1:0]   pos;
  logic            insert;
  logic [KW-1:0]   count_after;
  slot_t           fresh;

  always_comb begin
    // effective K: zero acts as one, saturate at the slot/result cap
    k4 = (max_lights == '0) ? ML_W'(1) : max_lights;
    if (k4 > ML_W'(CAP)) k4 = ML_W'(CAP);
    k = KW'(k4);

    fill_eff = (fill > k) ? k : fill;

    // kept entries are sorted, so le[] is a prefix mask
    for (int i = 0; i < SLOTS; i++) begin
      le[i] = (KW'(i) < fill_eff) && (slots[i].sq_dist <= item.sq_dist);
    end
    pos    = KW'($countones(le));
    insert = (pos < k);

    fresh.id      = item.id;
    fresh.sq_dist = item.sq_dist;

    list[0] = (insert && !le[0]) ? fresh : slots[0];
    for (int i = 1; i < SLOTS; i++) begin
      if (!insert || le[i]) begin
        list[i] = slots[i];
      end else if (le[i-1]) begin
        list[i] = fresh;
      end else begin
        list[i] = slots[i-1];
      end
    end

    count_after = (insert && fill_eff < k) ? fill_eff + KW'(1) : fill_eff;
    load        = item.valid && item.last && adv;
    load_count  = count_after;
    fill_next   = item.last ? '0 : count_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (item.valid && adv) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && adv) begin
      for (int i = 0; i < SLOTS; i++) begin
        slots[i] <= list[i];
      end
    end
  end

endmodule

>>> hdl/kps_emit.sv
`timescale 1ns / 1ps

module kps_emit #(
  parameter int SLOTS = 8,
  parameter int KW    = $clog2(SLOTS + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic [KW-1:0]        load_count,
  input  kps_pkg::slot_t       list [SLOTS],
  output logic                 free,
  kps_result_if.source         result
);
  import kps_pkg::*;

  slot_t             buffer [SLOTS];
  logic [KW-1:0]     remaining;
  logic [RANK_W-1:0] rank;
  logic              xfer;

  always_comb begin
    xfer                    = (remaining != '0) && result.ready;
    free                    = (remaining == '0) || ((remaining == KW'(1)) && result.ready);
    result.valid            = (remaining != '0);
    result.rank             = rank;
    result.chosen_id        = buffer[0].id;
    result.squared_distance = buffer[0].sq_dist;
    result.last_result      = (remaining == KW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      rank      <= '0;
    end else if (load) begin
      remaining <= load_count;
      rank      <= '0;
    end else if (xfer) begin
      remaining <= remaining - KW'(1);
      rank      <= rank + RANK_W'(1);
    end
  end

  // head of the buffer is always the next result
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < SLOTS; i++) begin
        buffer[i] <= list[i];
      end
    end else if (xfer) begin
      for (int i = 0; i < SLOTS - 1; i++) begin
        buffer[i] <= buffer[i+1];
      end
    end
  end

endmodule

>>> hdl/k_nearest_point_selector_unit.sv
`timescale 1ns / 1ps
// k_nearest_point_selector_unit
// Streams candidate points on the light channel (id, x/y/z signed Q8.8,
// last_light) and keeps the max_lights nearest to the query position,
// nearest first, ties kept in arrival order.
// Config: wr_en/wr_index/wr_data write query_x, query_y, query_z, max_lights;
// write only while the block is idle.
// Throughput: one candidate transfer per cycle while light.ready is high.
// The three-stage distance pipe (capture, per-axis square, sum) feeds a
// parallel compare-insert over all slots, one candidate each cycle.
// Results go out one per cycle while result.ready is high, rank 0 first,
// last_result on the final one (1 to max_lights results, 0 counting as 1,
// capped at SLOTS and RESULT_LIMIT). A finished list is copied into an
// output buffer as its last_light candidate leaves the sum stage, so the
// next list streams in while results drain. A last_light candidate at the
// insert stage while the buffer holds more than one pending result, or one
// not being taken, stalls the whole pipe (light.ready low) until it frees.
// Receiver stall: results hold stable while result.ready is low.
// Reset (rst, synchronous): empties pipe, slot list and buffer; query
// registers go to 0 and max_lights to 4.
module k_nearest_point_selector_unit #(
  parameter int SLOTS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [1:0]                    wr_index,
  input  logic [kps_pkg::COORD_W-1:0]   wr_data,
  kps_light_if.sink                     light,
  kps_result_if.source                  result
);
  import kps_pkg::*;

  localparam int KW = $clog2(SLOTS + 1);

  // configuration registers
  logic signed [COORD_W-1:0] query_x;
  logic signed [COORD_W-1:0] query_y;
  logic signed [COORD_W-1:0] query_z;
  logic [ML_W-1:0]           max_lights;

  always_ff @(posedge clk) begin
    if (rst) begin
      query_x    <= '0;
      query_y    <= '0;
      query_z    <= '0;
      max_lights <= ML_RESET;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_QUERY_X:    query_x    <= wr_data;
        REG_QUERY_Y:    query_y    <= wr_data;
        REG_QUERY_Z:    query_z    <= wr_data;
        REG_MAX_LIGHTS: max_lights <= wr_data[ML_W-1:0];
        default: ;
      endcase
    end
  end

  light_t     in_light;
  dist_item_t item;
  logic       adv;
  logic       load;
  logic       free;
  logic [KW-1:0] load_count;
  slot_t      list [SLOTS];

  // pipe moves unless a finished list has nowhere to go
  assign adv         = !(item.valid && item.last && !free);
  assign light.ready = adv;

  always_comb begin
    in_light.id   = light.light_id;
    in_light.x    = light.light_x;
    in_light.y    = light.light_y;
    in_light.z    = light.light_z;
    in_light.last = light.last_light;
  end

  kps_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (light.valid),
    .in_light (in_light),
    .query_x  (query_x),
    .query_y  (query_y),
    .query_z  (query_z),
    .item     (item)
  );

  kps_sorter #(.SLOTS(SLOTS), .KW(KW)) u_sorter (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .item       (item),
    .max_lights (max_lights),
    .load       (load),
    .load_count (load_count),
    .list       (list)
  );

  kps_emit #(.SLOTS(SLOTS), .KW(KW)) u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .load_count (load_count),
    .list       (list),
    .free       (free),
    .result     (result)
  );

endmodule

>>> hdl/kps_checker.sv
`timescale 1ns / 1ps

module kps_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [kps_pkg::RANK_W-1:0]    rank,
  input logic [kps_pkg::ID_W-1:0]      chosen_id,
  input logic [kps_pkg::DIST_W-1:0]    squared_distance,
  input logic                          last_result
);
  import kps_pkg::*;

  logic xfer;
  assign xfer = out_valid && out_ready;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(chosen_id) &&
      $stable(squared_distance) && $stable(rank) && $stable(last_result))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered right after reset");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    xfer && !last_result |=> out_valid && (rank == $past(rank) + RANK_W'(1)))
    else $error("run broke off or rank skipped");

  a_run_sorted: assert property (@(posedge clk) disable iff (rst)
    xfer && !last_result |=> squared_distance >= $past(squared_distance))
    else $error("results not nearest first");

  a_new_run_rank0: assert property (@(posedge clk) disable iff (rst)
    xfer && last_result |=> !out_valid || (rank == '0))
    else $error("new run does not start at rank zero");

endmodule

bind k_nearest_point_selector_unit kps_checker u_kps_checker (
  .clk              (clk),
  .rst              (rst),
  .out_valid        (result.valid),
  .out_ready        (result.ready),
  .rank             (result.rank),
  .chosen_id        (result.chosen_id),
  .squared_distance (result.squared_distance),
  .last_result      (result.last_result)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import kps_pkg::*;

  localparam int SLOT_COUNT   = 8;
  localparam int RANDOM_ITEMS = 100;
  // Quiet cycles after the last expected result before touching config.
  // Covers the 3-stage distance pipe plus the insert stage with margin.
  localparam int DRAIN_CYCLES = 10;

  // One reported neighbor, in the order the block sends them.
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] sq_dist;
    logic              last;
  } ranked_point_t;

  // Scoreboard: tracks the nearest-point list the block should hold and
  // queues the ranked results each last_light candidate releases.
  class nearest_scoreboard;
    logic signed [COORD_W-1:0] query [3];
    logic [ML_W-1:0]           max_lights;
    logic [ID_W-1:0]           kept_id   [SLOT_COUNT];
    logic [DIST_W-1:0]         kept_dist [SLOT_COUNT];
    int                        kept_count;
    ranked_point_t             pending [$];
    int                        errors;

    function new();
      foreach (query[a]) query[a] = '0;
      max_lights = ML_RESET;
      kept_count = 0;
      errors     = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [COORD_W-1:0] value);
      case (idx)
        REG_QUERY_X:    query[0] = value;
        REG_QUERY_Y:    query[1] = value;
        REG_QUERY_Z:    query[2] = value;
        REG_MAX_LIGHTS: max_lights = value[ML_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DIST_W-1:0] axis_square(logic signed [COORD_W-1:0] a,
                                             logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      longint                  m;
      d = a - b;
      m = d;
      return DIST_W'(m * m);
    endfunction

    function void note_light(light_t pt);
      logic [DIST_W-1:0] sq_dist;
      int                k;
      int                pos;
      int                n;
      ranked_point_t     entry;
      // 0 acts as 1; anything above the slot count or result limit saturates
      k = (max_lights == 0) ? 1 : int'(max_lights);
      if (k > SLOT_COUNT) k = SLOT_COUNT;
      if (k > RESULT_LIMIT) k = RESULT_LIMIT;
      sq_dist = axis_square(pt.x, query[0]) + axis_square(pt.y, query[1]) +
                axis_square(pt.z, query[2]);
      // K lowered mid-list: the farther entries fall off first
      if (kept_count > k) kept_count = k;
      // equal distances keep arrival order, so step past them
      pos = 0;
      while (pos < kept_count && kept_dist[pos] <= sq_dist) pos++;
      if (pos < k) begin
        n = (kept_count < k) ? kept_count : k - 1;
        for (int i = n; i > pos; i--) begin
          kept_id[i]   = kept_id[i-1];
          kept_dist[i] = kept_dist[i-1];
        end
        kept_id[pos]   = pt.id;
        kept_dist[pos] = sq_dist;
        if (kept_count < k) kept_count++;
      end
      if (pt.last) begin
        for (int i = 0; i < kept_count; i++) begin
          entry = '{rank: RANK_W'(i), id: kept_id[i], sq_dist: kept_dist[i],
                    last: (i == kept_count - 1)};
          pending.insert(pending.size(), entry);
        end
        kept_count = 0;
      end
    endfunction

    function void mismatch(string field, logic [DIST_W-1:0] want, logic [DIST_W-1:0] got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      errors++;
    endfunction

    function void check_result(ranked_point_t got);
      ranked_point_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, got rank %0d id %0d dist %0d last %b",
                 $time, got.rank, got.id, got.sq_dist, got.last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.rank !== want.rank)
        mismatch("rank", DIST_W'(want.rank), DIST_W'(got.rank));
      if (got.id !== want.id)
        mismatch("chosen_id", DIST_W'(want.id), DIST_W'(got.id));
      if (got.sq_dist !== want.sq_dist)
        mismatch("squared_distance", want.sq_dist, got.sq_dist);
      if (got.last !== want.last)
        mismatch("last_result", DIST_W'(want.last), DIST_W'(got.last));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en = 1'b0;
  logic [1:0]           wr_index = '0;
  logic [COORD_W-1:0]   wr_data = '0;
  logic [COORD_W-1:0]   cur_query [3];
  bit                   steady;
  int                   sent;

  nearest_scoreboard sb = new();

  kps_light_if  light_ch();
  kps_result_if result_ch();

  k_nearest_point_selector_unit #(.SLOTS(SLOT_COUNT)) dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .light    (light_ch),
    .result   (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Generous cap: worst case every result waits the longest receiver stall.
  initial begin
    #2_000_000;
    $display("FAIL k_nearest_point_selector_unit");
    $finish;
  end

  // Per-item idle draw shared by both sides; steady stretches have none.
  function automatic int draw_gap();
    if (steady) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic light_t point(logic [ID_W-1:0] id, logic [COORD_W-1:0] x,
                                   logic [COORD_W-1:0] y, logic [COORD_W-1:0] z,
                                   logic last);
    return '{id: id, x: x, y: y, z: z, last: last};
  endfunction

  // Mix of wide random points, tight clusters around the query (lots of
  // equal distances), mid-range offsets, and exact repeats of the previous
  // point so ties get exercised.
  function automatic light_t random_point(light_t prev, logic last);
    logic [COORD_W-1:0] c [3];
    int                 mode;
    mode = $urandom_range(0, 9);
    for (int a = 0; a < 3; a++) begin
      if (mode < 2)
        c[a] = COORD_W'($urandom());
      else if (mode < 6)
        c[a] = cur_query[a] + COORD_W'($urandom_range(0, 6)) - COORD_W'(3);
      else if (mode < 8)
        c[a] = cur_query[a] + COORD_W'($urandom_range(0, 4000)) - COORD_W'(2000);
    end
    if (mode >= 8) begin
      c[0] = prev.x;
      c[1] = prev.y;
      c[2] = prev.z;
    end
    return point(ID_W'($urandom()), c[0], c[1], c[2], last);
  endfunction

  function automatic logic [COORD_W-1:0] random_coord();
    logic [COORD_W-1:0] corners [4];
    corners = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    if ($urandom_range(0, 3) == 0) return corners[$urandom_range(0, 3)];
    return COORD_W'($urandom());
  endfunction

  // Writes all four registers on consecutive cycles. Called at a falling
  // edge with the block idle; returns at a falling edge.
  task automatic configure(input logic [COORD_W-1:0] qx, input logic [COORD_W-1:0] qy,
                           input logic [COORD_W-1:0] qz, input logic [ML_W-1:0] ml);
    reg_index_t         idx [4];
    logic [COORD_W-1:0] val [4];
    idx = '{REG_QUERY_X, REG_QUERY_Y, REG_QUERY_Z, REG_MAX_LIGHTS};
    val = '{qx, qy, qz, COORD_W'(ml)};
    cur_query = '{qx, qy, qz};
    for (int i = 0; i < 4; i++) begin
      wr_en    <= 1'b1;
      wr_index <= idx[i];
      wr_data  <= val[i];
      sb.set_reg(idx[i], val[i]);
      @(negedge clk);
    end
    wr_en <= 1'b0;
  endtask

  // One candidate transfer. Entered and left at a falling edge; valid is
  // only touched once per edge so back-to-back items keep it high.
  task automatic send_light(input light_t item);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      light_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    light_ch.valid      <= 1'b1;
    light_ch.light_id   <= item.id;
    light_ch.light_x    <= item.x;
    light_ch.light_y    <= item.y;
    light_ch.light_z    <= item.z;
    light_ch.last_light <= item.last;
    do @(posedge clk); while (light_ch.ready !== 1'b1);
    sb.note_light(item);
    sent++;
    @(negedge clk);
  endtask

  // Idle the sender, wait out every pending result, then let the pipe empty
  // (a trailing non-last candidate still sits in it with nothing to show).
  task automatic drain();
    light_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Result receiver: random stall before each transfer, checked at the
  // rising edge where valid and ready are both high.
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
      sb.check_result('{rank: result_ch.rank, id: result_ch.chosen_id,
                        sq_dist: result_ch.squared_distance,
                        last: result_ch.last_result});
      @(negedge clk);
    end
  end

  initial begin
    light_t prev;
    int     lists;
    int     len;
    int     target;
    bit     leave_open;

    light_ch.valid      = 1'b0;
    light_ch.light_id   = '0;
    light_ch.light_x    = '0;
    light_ch.light_y    = '0;
    light_ch.light_z    = '0;
    light_ch.last_light = 1'b0;
    cur_query = '{default: '0};
    steady = 1'b0;
    sent   = 0;
    prev   = '0;

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset config (query at origin, four kept). Corner coordinates give the
    // largest distances; four points at distance 0 or 1 then push them out.
    // The last candidate ties the farthest kept one and must not get in.
    send_light(point(16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
    send_light(point(16'hFFFF, 16'h8000, 16'h8000, 16'h8000, 1'b0));
    send_light(point(16'h0001, 16'h0001, 16'h0000, 16'h0000, 1'b0));
    send_light(point(16'h0002, 16'h0000, 16'hFFFF, 16'h0000, 1'b0));
    send_light(point(16'h0003, 16'h0000, 16'h0000, 16'h0001, 1'b0));
    send_light(point(16'h0004, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_light(point(16'h0005, 16'hFFFF, 16'h0000, 16'h0000, 1'b1));
    drain();

    // Query in the corners, one kept: the first point sits at the largest
    // possible distance, a nearer one replaces it, an equal one does not.
    configure(16'h8000, 16'h7FFF, 16'h8000, 4'd1);
    send_light(point(16'hA5A5, 16'h7FFF, 16'h8000, 16'h7FFF, 1'b0));
    send_light(point(16'h5A5A, 16'h0000, 16'h0000, 16'h0000, 1'b0));
    send_light(point(16'h1234, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    drain();

    // max_lights of zero still keeps one; single-candidate list.
    configure(16'h0000, 16'h0000, 16'h0000, 4'd0);
    send_light(point(16'hBEEF, 16'h0100, 16'hFF00, 16'h0080, 1'b1));
    drain();

    // max_lights far above the slot count saturates; arriving farthest
    // first forces a shift on every insert and two evictions.
    configure(16'h0040, 16'hFFC0, 16'h0010, 4'd15);
    steady = 1'b1;
    for (int i = 0; i < 10; i++)
      send_light(point(ID_W'(16'h0100 + i), COORD_W'(16'h0040 + (10 - i) * 16'h0200),
                       16'hFFC0, 16'h0010, i == 9));
    drain();
    steady = 1'b0;

    // List left open, then max_lights lowered: only the two nearest survive
    // and the closing candidate is too far to get in.
    configure(16'h0000, 16'h0000, 16'h0000, 4'd8);
    send_light(point(16'h0020, 16'h0003, 16'h0000, 16'h0000, 1'b0));
    send_light(point(16'h0021, 16'h0001, 16'h0000, 16'h0000, 1'b0));
    send_light(point(16'h0022, 16'h0002, 16'h0000, 16'h0000, 1'b0));
    drain();
    configure(16'h0000, 16'h0000, 16'h0000, 4'd2);
    send_light(point(16'h0023, 16'hFFFD, 16'h0000, 16'h0000, 1'b1));
    drain();

    // Random phases: optional reconfig, a few lists of random length (some
    // longer than any K), sometimes ending with the list still open so the
    // next phase inherits it.
    target = sent + RANDOM_ITEMS;
    while (sent < target) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) != 0)
        configure(random_coord(), random_coord(), random_coord(),
                  ($urandom_range(0, 4) == 0) ? ML_W'($urandom_range(0, 15))
                                              : ML_W'($urandom_range(1, 8)));
      lists = $urandom_range(1, 3);
      for (int l = 0; l < lists; l++) begin
        len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
        leave_open = (l == lists - 1) && ($urandom_range(0, 5) == 0);
        for (int j = 0; j < len; j++) begin
          prev = random_point(prev, (j == len - 1) && !leave_open);
          send_light(prev);
        end
      end
      drain();
    end

    if (sb.errors == 0)
      $display("PASS k_nearest_point_selector_unit");
    else
      $display("FAIL k_nearest_point_selector_unit");
    $finish;
  end

endmodule

>>> sim.f
hdl/kps_pkg.sv
hdl/kps_channels.sv
hdl/kps_dist.sv
hdl/kps_sorter.sv
hdl/kps_emit.sv
hdl/k_nearest_point_selector_unit.sv
hdl/kps_checker.sv
tb/tb_top.sv
